FILE: rtl/projected_gauss_seidel_solver_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the projected Gauss-Seidel solver
// Clocked assertion wrappers that share the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef PROJECTED_GAUSS_SEIDEL_SOLVER_ASSERT_SVH
`define PROJECTED_GAUSS_SEIDEL_SOLVER_ASSERT_SVH

// check a property on every clock edge out of reset
`define PGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define PGS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/pgs_pkg.sv
// ----------------------------------------------------------------------------
// Projected Gauss-Seidel solver package
// Sizes, opcodes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package pgs_pkg;

  localparam int MAX_SIZE  = 16;
  localparam int IDX_W     = $clog2(MAX_SIZE);
  localparam int CNT_W     = $clog2(MAX_SIZE + 1);
  localparam int MAT_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int DIV_CNT_W = $clog2(ACC_W);

  localparam logic [7:0]  ITER_LIMIT_RST = 8'd20;
  localparam logic [31:0] ERR_THRESH_RST = 32'd429;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_LOAD_X = 2'd2,
    OP_SOLVE  = 2'd3
  } opcode_t;

  typedef enum logic {
    CFG_ITER_LIMIT = 1'b0,
    CFG_ERR_THRESH = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_INIT,
    ST_COL_RD,
    ST_COL_MUL,
    ST_COL_ACC,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_ERR_MUL,
    ST_ERR_ACC,
    ST_CHECK,
    ST_OUT
  } state_t;

endpackage

FILE: rtl/pgs_in_if.sv
// ----------------------------------------------------------------------------
// Solver input channel
// Valid/ready channel carrying one load or solve item.
// ----------------------------------------------------------------------------
interface pgs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  row;
  logic [3:0]  column;
  logic signed [31:0] value;
  logic [4:0]  size;

  modport source (output valid, opcode, row, column, value, size, input ready);
  modport sink   (input valid, opcode, row, column, value, size, output ready);
endinterface

FILE: rtl/pgs_out_if.sv
// ----------------------------------------------------------------------------
// Solver result channel
// Valid/ready channel carrying one solution element.
// ----------------------------------------------------------------------------
interface pgs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic signed [31:0] solution;
  logic        last;
  logic        converged;

  modport source (output valid, index, solution, last, converged, input ready);
  modport sink   (input valid, index, solution, last, converged, output ready);
endinterface

FILE: rtl/pgs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/projected_gauss_seidel_solver.sv
// Load items are accepted while the block is idle; a solve item is accepted and the block
// is busy until its last result item is taken. A sweep passes each row through the shared
// multiplier, column by column, and then, unless the result is forced to zero, through the
// bit-serial divider. A run is up to iteration_limit sweeps, then n result items.
// Reset (rst_n low, synchronous) clears control, the solution vector and the registers
// (limit 20, threshold 429); matrix and b stores are undefined until loaded.
// ----------------------------------------------------------------------------
// Projected Gauss-Seidel LCP solver
// Q16.16 fixed-point solver sharing one multiplier and one serial divider.
// ----------------------------------------------------------------------------
`include "projected_gauss_seidel_solver_assert.svh"

module projected_gauss_seidel_solver (
  input  logic        clk,
  input  logic        rst_n,
  pgs_in_if.sink      in_item,
  pgs_out_if.source   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  pgs_pkg::state_t state_r, state_nxt;

  logic [7:0]  limit_r;
  logic [31:0] thresh_r;

  logic [pgs_pkg::CNT_W-1:0] n_r, i_r, j_r;
  logic [7:0]  k_r;
  logic [63:0] num_r, prod_r, err_r, quo_r;
  logic [31:0] d_r, dmag_r, rem_r;
  logic [pgs_pkg::DIV_CNT_W-1:0] dcnt_r;
  logic        conv_r;

  logic [31:0] cur_r  [pgs_pkg::MAX_SIZE];
  logic [31:0] prev_r [pgs_pkg::MAX_SIZE];
  logic [31:0] b_r    [pgs_pkg::MAX_SIZE];

  logic [pgs_pkg::CNT_W-1:0] sz_clamp;
  logic [31:0] ram_rdata, x_op, cur_j, prev_j;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [64:0] sub_w, add_w;
  logic [63:0] sub_sat, num_mag;
  logic [32:0] diff_w, div_shift;
  logic [31:0] diff_mag;
  logic        div_skip, j_is_i, j_last, in_acc, out_acc;

  assign in_acc  = in_item.valid && in_item.ready;
  assign out_acc = out_item.valid && out_item.ready;

  assign cur_j  = cur_r[j_r[pgs_pkg::IDX_W-1:0]];
  assign prev_j = prev_r[j_r[pgs_pkg::IDX_W-1:0]];
  assign x_op   = (j_r < i_r) ? cur_j : prev_j;
  assign j_is_i = (j_r == i_r);
  assign j_last = (j_r == n_r - pgs_pkg::CNT_W'(1));

  pgs_ram #(
    .WIDTH (pgs_pkg::DATA_W),
    .DEPTH (pgs_pkg::MAT_DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (in_acc && (in_item.opcode == pgs_pkg::OP_LOAD_A)),
    .waddr ({in_item.row, in_item.column}),
    .wdata (in_item.value),
    .raddr ({i_r[pgs_pkg::IDX_W-1:0], j_r[pgs_pkg::IDX_W-1:0]}),
    .rdata (ram_rdata)
  );

  // shared multiplier: matrix product or squared change
  assign diff_w   = {cur_j[31], cur_j} - {prev_j[31], prev_j};
  assign diff_mag = diff_w[32] ? 32'(-diff_w) : diff_w[31:0];

  always_comb begin
    if (state_r == pgs_pkg::ST_ERR_MUL) begin
      mul_a = {1'b0, diff_mag};
      mul_b = {1'b0, diff_mag};
    end else begin
      mul_a = {ram_rdata[31], ram_rdata};
      mul_b = {x_op[31], x_op};
    end
  end
  assign mul_p = mul_a * mul_b;

  // saturating subtract and add
  assign sub_w   = {num_r[63], num_r} - {prod_r[63], prod_r};
  assign sub_sat = (sub_w[64] != sub_w[63]) ?
                   (sub_w[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sub_w[63:0];
  assign add_w   = {1'b0, err_r} + {1'b0, prod_r};

  assign num_mag   = num_r[63] ? 64'(-num_r) : num_r;
  assign div_skip  = (d_r == 32'd0) || (num_r[63] != d_r[31]);
  assign div_shift = {rem_r, quo_r[63]};

  always_comb begin
    if (in_item.size == 5'd0) begin
      sz_clamp = pgs_pkg::CNT_W'(1);
    end else if (in_item.size > 5'(pgs_pkg::MAX_SIZE)) begin
      sz_clamp = pgs_pkg::CNT_W'(pgs_pkg::MAX_SIZE);
    end else begin
      sz_clamp = pgs_pkg::CNT_W'(in_item.size);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pgs_pkg::ST_IDLE: begin
        if (in_acc && (in_item.opcode == pgs_pkg::OP_SOLVE)) begin
          state_nxt = (limit_r == 8'd0) ? pgs_pkg::ST_OUT : pgs_pkg::ST_ROW_INIT;
        end
      end
      pgs_pkg::ST_ROW_INIT:  state_nxt = pgs_pkg::ST_COL_RD;
      pgs_pkg::ST_COL_RD:    state_nxt = pgs_pkg::ST_COL_MUL;
      pgs_pkg::ST_COL_MUL:   state_nxt = pgs_pkg::ST_COL_ACC;
      pgs_pkg::ST_COL_ACC:   state_nxt = j_last ? pgs_pkg::ST_DIV_START : pgs_pkg::ST_COL_RD;
      pgs_pkg::ST_DIV_START: begin
        if (!div_skip) begin
          state_nxt = pgs_pkg::ST_DIV_RUN;
        end else if (i_r == n_r - pgs_pkg::CNT_W'(1)) begin
          state_nxt = pgs_pkg::ST_ERR_MUL;
        end else begin
          state_nxt = pgs_pkg::ST_ROW_INIT;
        end
      end
      pgs_pkg::ST_DIV_RUN: begin
        if (dcnt_r == {pgs_pkg::DIV_CNT_W{1'b1}}) begin
          state_nxt = pgs_pkg::ST_DIV_DONE;
        end
      end
      pgs_pkg::ST_DIV_DONE: begin
        state_nxt = (i_r == n_r - pgs_pkg::CNT_W'(1)) ? pgs_pkg::ST_ERR_MUL
                                                      : pgs_pkg::ST_ROW_INIT;
      end
      pgs_pkg::ST_ERR_MUL:   state_nxt = pgs_pkg::ST_ERR_ACC;
      pgs_pkg::ST_ERR_ACC:   state_nxt = j_last ? pgs_pkg::ST_CHECK : pgs_pkg::ST_ERR_MUL;
      pgs_pkg::ST_CHECK: begin
        if ((err_r < {32'd0, thresh_r}) || (k_r + 8'd1 == limit_r)) begin
          state_nxt = pgs_pkg::ST_OUT;
        end else begin
          state_nxt = pgs_pkg::ST_ROW_INIT;
        end
      end
      pgs_pkg::ST_OUT: begin
        if (out_acc && j_last) begin
          state_nxt = pgs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pgs_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= pgs_pkg::ITER_LIMIT_RST;
      thresh_r <= pgs_pkg::ERR_THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pgs_pkg::CFG_ITER_LIMIT: limit_r  <= cfg_data[7:0];
        pgs_pkg::CFG_ERR_THRESH: thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // solution vector, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < pgs_pkg::MAX_SIZE; e++) begin
        cur_r[e] <= 32'd0;
      end
    end else begin
      case (state_r)
        pgs_pkg::ST_IDLE: begin
          if (in_acc && (in_item.opcode == pgs_pkg::OP_LOAD_X)) begin
            cur_r[in_item.row] <= in_item.value;
          end else if (in_acc && (in_item.opcode == pgs_pkg::OP_SOLVE)) begin
            for (int e = 0; e < pgs_pkg::MAX_SIZE; e++) begin
              if (pgs_pkg::CNT_W'(e) < sz_clamp) begin
                cur_r[e] <= 32'd0;
              end
            end
          end
        end
        pgs_pkg::ST_DIV_START: begin
          if (div_skip) begin
            cur_r[i_r[pgs_pkg::IDX_W-1:0]] <= 32'd0;
          end
        end
        pgs_pkg::ST_DIV_DONE: begin
          cur_r[i_r[pgs_pkg::IDX_W-1:0]] <= (|quo_r[63:31]) ? 32'h7FFF_FFFF
                                                           : {1'b0, quo_r[30:0]};
        end
        default: ;
      endcase
    end
  end

  // datapath and sequencer counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      i_r    <= '0;
      j_r    <= '0;
      k_r    <= '0;
      dcnt_r <= '0;
      conv_r <= 1'b0;
    end else begin
      case (state_r)
        pgs_pkg::ST_IDLE: begin
          if (in_acc && (in_item.opcode == pgs_pkg::OP_LOAD_B)) begin
            b_r[in_item.row] <= in_item.value;
          end
          if (in_acc && (in_item.opcode == pgs_pkg::OP_SOLVE)) begin
            n_r    <= sz_clamp;
            i_r    <= '0;
            j_r    <= '0;
            k_r    <= '0;
            conv_r <= 1'b0;
            for (int e = 0; e < pgs_pkg::MAX_SIZE; e++) begin
              if (pgs_pkg::CNT_W'(e) < sz_clamp) begin
                prev_r[e] <= cur_r[e];
              end
            end
          end
        end
        pgs_pkg::ST_ROW_INIT: begin
          // numerator starts at -b in Q32.32
          num_r <= 64'(-({{32{b_r[i_r[pgs_pkg::IDX_W-1:0]][31]}},
                          b_r[i_r[pgs_pkg::IDX_W-1:0]]} << 16));
          j_r   <= '0;
        end
        pgs_pkg::ST_COL_MUL: begin
          if (j_is_i) begin
            d_r <= ram_rdata;
          end else begin
            prod_r <= mul_p[63:0];
          end
        end
        pgs_pkg::ST_COL_ACC: begin
          if (!j_is_i) begin
            num_r <= sub_sat;
          end
          j_r <= j_r + pgs_pkg::CNT_W'(1);
        end
        pgs_pkg::ST_DIV_START: begin
          quo_r  <= num_mag;
          rem_r  <= '0;
          dmag_r <= d_r[31] ? 32'(-d_r) : d_r;
          dcnt_r <= '0;
          if (div_skip) begin
            i_r   <= i_r + pgs_pkg::CNT_W'(1);
            j_r   <= '0;
            err_r <= '0;
          end
        end
        pgs_pkg::ST_DIV_RUN: begin
          // one quotient bit per cycle, restoring
          if (div_shift >= {1'b0, dmag_r}) begin
            rem_r <= 32'(div_shift - {1'b0, dmag_r});
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= div_shift[31:0];
            quo_r <= {quo_r[62:0], 1'b0};
          end
          dcnt_r <= dcnt_r + pgs_pkg::DIV_CNT_W'(1);
        end
        pgs_pkg::ST_DIV_DONE: begin
          i_r   <= i_r + pgs_pkg::CNT_W'(1);
          j_r   <= '0;
          err_r <= '0;
        end
        pgs_pkg::ST_ERR_MUL: begin
          prod_r <= mul_p[63:0];
        end
        pgs_pkg::ST_ERR_ACC: begin
          err_r <= add_w[64] ? {64{1'b1}} : add_w[63:0];
          j_r   <= j_r + pgs_pkg::CNT_W'(1);
        end
        pgs_pkg::ST_CHECK: begin
          i_r <= '0;
          j_r <= '0;
          if (err_r < {32'd0, thresh_r}) begin
            conv_r <= 1'b1;
          end else begin
            k_r <= k_r + 8'd1;
            for (int e = 0; e < pgs_pkg::MAX_SIZE; e++) begin
              prev_r[e] <= cur_r[e];
            end
          end
        end
        pgs_pkg::ST_OUT: begin
          if (out_acc) begin
            j_r <= j_r + pgs_pkg::CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign in_item.ready      = (state_r == pgs_pkg::ST_IDLE);
  assign out_item.valid     = (state_r == pgs_pkg::ST_OUT);
  assign out_item.index     = j_r[pgs_pkg::IDX_W-1:0];
  assign out_item.solution  = cur_j;
  assign out_item.last      = j_last;
  assign out_item.converged = conv_r;

  `PGS_ASSERT(a_no_overlap, in_item.ready |-> !out_item.valid, "ready while results pending")
  `PGS_ASSERT(a_nonneg, out_item.valid |-> !out_item.solution[31], "negative solution")
  `PGS_ASSERT(a_solve_busy, (in_acc && (in_item.opcode == pgs_pkg::OP_SOLVE)) |=> !in_item.ready, "ready after solve")
  `PGS_ASSERT(a_last_idle, (out_acc && out_item.last) |=> in_item.ready, "not idle after last item")

endmodule

FILE: verif/projected_gauss_seidel_solver_tb.sv
// ----------------------------------------------------------------------------
// Projected Gauss-Seidel solver testbench
// Drives load and solve items with random gaps and random result stalls. A
// built-in fixed-point predictor works out every solution run, and each item
// taken from the result channel is checked against the oldest expectation.
// ----------------------------------------------------------------------------
module projected_gauss_seidel_solver_tb;

  localparam int IDLE_LIMIT  = 250000;
  localparam int COST_BUDGET = 40000;

  typedef struct {
    logic [3:0]         index;
    logic signed [31:0] solution;
    logic               last;
    logic               converged;
  } sol_item_t;

  typedef struct {
    pgs_pkg::opcode_t op;
    logic [3:0]  row;
    logic [3:0]  column;
    logic [31:0] value;
    logic [4:0]  size;
    bit          typed;
    logic [31:0] sol;
    bit          conv;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  pgs_in_if  in_ch ();
  pgs_out_if out_ch ();

  projected_gauss_seidel_solver uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch.sink),
    .out_item (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor state
  logic signed [31:0] a_mat [16][16];
  logic signed [31:0] b_vec [16];
  logic signed [31:0] x_cur [16];
  logic signed [31:0] x_prev [16];
  bit                 a_wr [16][16];
  bit                 b_wr [16];
  logic [7:0]         lim_reg;
  logic [31:0]        thr_reg;

  sol_item_t solution_q[$];
  int fail_count;
  int items_sent;
  int solves_sent;
  int results_checked;
  int idle_cycles;
  int out_hold;
  bit no_idle;

  dir_row_t dir_rows [24] = '{
    '{pgs_pkg::OP_LOAD_A, 4'd0,  4'd0,  32'h00010000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_B, 4'd0,  4'd0,  32'hFFFE0000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_SOLVE,  4'd0,  4'd0,  32'h0,        5'd1,  1'b1, 32'h00020000, 1'b1},
    // zero diagonal, size zero taken as one
    '{pgs_pkg::OP_LOAD_A, 4'd0,  4'd0,  32'h0,        5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_SOLVE,  4'd0,  4'd0,  32'h0,        5'd0,  1'b1, 32'h0, 1'b1},
    // tiny diagonal against the most negative offset: quotient saturates
    '{pgs_pkg::OP_LOAD_A, 4'd0,  4'd0,  32'h00000001, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_B, 4'd0,  4'd0,  32'h80000000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_SOLVE,  4'd0,  4'd0,  32'h0,        5'd1,  1'b1, 32'h7FFFFFFF, 1'b1},
    // negative quotient clamps to zero
    '{pgs_pkg::OP_LOAD_B, 4'd0,  4'd0,  32'h7FFFFFFF, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_A, 4'd0,  4'd0,  32'h00010000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_SOLVE,  4'd0,  4'd0,  32'h0,        5'd1,  1'b1, 32'h0, 1'b1},
    // negative guess and negative diagonal
    '{pgs_pkg::OP_LOAD_X, 4'd0,  4'd0,  32'hFFFF0000, 5'd31, 1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_A, 4'd0,  4'd0,  32'hFFFF0000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_B, 4'd0,  4'd0,  32'h00010000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_SOLVE,  4'd0,  4'd0,  32'h0,        5'd1,  1'b1, 32'h00010000, 1'b1},
    '{pgs_pkg::OP_LOAD_A, 4'd15, 4'd15, 32'h80000000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_B, 4'd15, 4'd0,  32'h7FFFFFFF, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_X, 4'd15, 4'd15, 32'hFFFFFFFF, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_A, 4'd1,  4'd15, 32'h12345678, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_A, 4'd0,  4'd1,  32'h00004000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_A, 4'd1,  4'd0,  32'hFFFFC000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_A, 4'd1,  4'd1,  32'h00020000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_LOAD_B, 4'd1,  4'd0,  32'hFFFF0000, 5'd0,  1'b0, 32'h0, 1'b0},
    '{pgs_pkg::OP_SOLVE,  4'd0,  4'd0,  32'h0,        5'd2,  1'b0, 32'h0, 1'b0}
  };

  logic [7:0]  lim_set [8] = '{8'd20, 8'd1, 8'd255, 8'd0, 8'd8, 8'd255, 8'd50, 8'd2};
  logic [31:0] thr_set [8] = '{32'd429, 32'd0, 32'hFFFFFFFF, 32'd1000, 32'd0, 32'd0,
                               32'h00010000, 32'h80000000};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    fail_count++;
  endtask

  // append one expected result item
  function automatic void add_expect(logic [3:0] idx, logic signed [31:0] s, logic l,
                                     logic c);
    sol_item_t it;
    it.index     = idx;
    it.solution  = s;
    it.last      = l;
    it.converged = c;
    solution_q   = {solution_q, it};
  endfunction

  function automatic logic signed [31:0] solve_row(int i, int n);
    longint num;
    longint prod;
    longint d;
    logic [64:0] t;
    longint unsigned mn;
    longint unsigned md;
    longint unsigned q;
    num = -(longint'(b_vec[i]) * 64'sd65536);
    d = longint'(a_mat[i][i]);
    for (int j = 0; j < n; j++) begin
      if (j == i) continue;
      prod = longint'(a_mat[i][j]) * longint'((j < i) ? x_cur[j] : x_prev[j]);
      t = {num[63], num} - {prod[63], prod};
      // saturate on signed overflow
      if (t[64] != t[63]) num = t[64] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
      else num = t[63:0];
    end
    if (d == 0) return 0;
    if ((num < 0) != (d < 0)) return 0;
    mn = (num < 0) ? (64'd0 - num) : num;
    md = (d < 0) ? (64'd0 - d) : d;
    q = mn / md;
    if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
    return q[31:0];
  endfunction

  task automatic predict_solve(logic [4:0] sz, bit push);
    int n;
    bit conv;
    longint dlt;
    longint unsigned m;
    longint unsigned err;
    logic [64:0] s65;
    n = (sz == 0) ? 1 : ((sz > 16) ? 16 : int'(sz));
    conv = 1'b0;
    for (int i = 0; i < n; i++) begin
      x_prev[i] = x_cur[i];
      x_cur[i] = 0;
    end
    for (int k = 0; k < int'(lim_reg); k++) begin
      err = 0;
      for (int i = 0; i < n; i++) x_cur[i] = solve_row(i, n);
      for (int i = 0; i < n; i++) begin
        dlt = longint'(x_cur[i]) - longint'(x_prev[i]);
        m = (dlt < 0) ? (64'd0 - dlt) : dlt;
        s65 = {1'b0, err} + {1'b0, m * m};
        err = s65[64] ? 64'hFFFFFFFFFFFFFFFF : s65[63:0];
      end
      if (err < {32'd0, thr_reg}) begin
        conv = 1'b1;
        break;
      end
      for (int i = 0; i < n; i++) x_prev[i] = x_cur[i];
    end
    if (push)
      for (int i = 0; i < n; i++)
        add_expect(4'(i), x_cur[i], (i == n - 1), conv);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(pgs_pkg::opcode_t op, logic [3:0] r, logic [3:0] c,
                           logic [31:0] v, logic [4:0] s, bit typed = 0,
                           logic [31:0] xs = 0, bit xc = 0);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.row    <= r;
    in_ch.column <= c;
    in_ch.value  <= v;
    in_ch.size   <= s;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    case (op)
      pgs_pkg::OP_LOAD_A: begin
        a_mat[r][c] = v;
        a_wr[r][c] = 1'b1;
      end
      pgs_pkg::OP_LOAD_B: begin
        b_vec[r] = v;
        b_wr[r] = 1'b1;
      end
      pgs_pkg::OP_LOAD_X: x_cur[r] = v;
      pgs_pkg::OP_SOLVE: begin
        solves_sent++;
        predict_solve(s, !typed);
        if (typed) add_expect(4'd0, xs, 1'b1, xc);
      end
      default: ;
    endcase
  endtask

  task automatic cfg_write(pgs_pkg::cfg_index_t idx, logic [31:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pgs_pkg::CFG_ITER_LIMIT) lim_reg = d[7:0];
    else thr_reg = d;
  endtask

  // hold until the block has drained, then allow for a load still in flight
  task automatic idle_wait();
    in_ch.valid <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0)
      send_item(pgs_pkg::opcode_t'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
                $urandom, 5'($urandom));
  endtask

  function automatic logic [31:0] coef(bit diag);
    logic [31:0] v;
    if ($urandom_range(0, 9) == 0) return $urandom;
    if (!diag) return $urandom_range(0, 32'h10000) - 32'h8000;
    v = $urandom_range(32'h20000, 32'h60000);
    return ($urandom_range(0, 9) == 0) ? -v : v;
  endfunction

  // random size up to the largest whose worst-case solve stays within the cycle budget
  function automatic int pick_n();
    int lim;
    int nmax;
    lim = (lim_reg == 0) ? 1 : int'(lim_reg);
    nmax = 1;
    while (nmax < 16 &&
           lim * ((nmax + 1) * (3 * (nmax + 1) + 67) + 2 * (nmax + 1) + 1) <= COST_BUDGET)
      nmax++;
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, nmax);
    return $urandom_range(1, (nmax < 4) ? nmax : 4);
  endfunction

  task automatic run_sequence(int n);
    logic [4:0] sz;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!a_wr[i][j] || $urandom_range(0, 3) == 0) begin
          maybe_noise();
          send_item(pgs_pkg::OP_LOAD_A, 4'(i), 4'(j), coef(i == j), 5'($urandom));
        end
    for (int i = 0; i < n; i++)
      if (!b_wr[i] || $urandom_range(0, 1) == 0)
        send_item(pgs_pkg::OP_LOAD_B, 4'(i), 4'($urandom),
                  $urandom_range(0, 32'h80000) - 32'h40000, 5'($urandom));
    if ($urandom_range(0, 2) == 0)
      for (int i = 0; i < n; i++)
        if ($urandom_range(0, 1) == 0)
          send_item(pgs_pkg::OP_LOAD_X, 4'(i), 4'($urandom),
                    $urandom_range(0, 32'h30000) - 32'h8000, 5'($urandom));
    sz = 5'(n);
    if (n == 1 && $urandom_range(0, 1) == 0) sz = 5'd0;
    if (n == 16) sz = 5'($urandom_range(16, 31));
    send_item(pgs_pkg::OP_SOLVE, 4'($urandom), 4'($urandom), $urandom, sz);
  endtask

  // result side: check, then choose the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (solution_q.size() == 0) begin
          report_mismatch("result item with nothing expected", 0, out_ch.index);
        end else begin
          sol_item_t want;
          want = solution_q.pop_front();
          results_checked++;
          if (out_ch.index !== want.index)
            report_mismatch("index", want.index, out_ch.index);
          if (out_ch.solution !== want.solution)
            report_mismatch("solution", want.solution, out_ch.solution);
          if (out_ch.last !== want.last)
            report_mismatch("last", want.last, out_ch.last);
          if (out_ch.converged !== want.converged)
            report_mismatch("converged", want.converged, out_ch.converged);
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ch.ready <= 1'b0;
      end else if (no_idle || $urandom_range(0, 9) < 7) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(9, 39);
        out_ch.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
        $display("projected_gauss_seidel_solver test failed");
        $finish;
      end
    end
  end

  initial begin
    int start;
    int p;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.row = '0;
    in_ch.column = '0;
    in_ch.value = '0;
    in_ch.size = '0;
    fail_count = 0;
    items_sent = 0;
    solves_sent = 0;
    results_checked = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    lim_reg = pgs_pkg::ITER_LIMIT_RST;
    thr_reg = pgs_pkg::ERR_THRESH_RST;
    for (int i = 0; i < 16; i++) begin
      x_cur[i] = 0;
      x_prev[i] = 0;
      b_vec[i] = 0;
      b_wr[i] = 1'b0;
      for (int j = 0; j < 16; j++) begin
        a_mat[i][j] = 0;
        a_wr[i][j] = 1'b0;
      end
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs at the reset register values
    foreach (dir_rows[k])
      send_item(dir_rows[k].op, dir_rows[k].row, dir_rows[k].column, dir_rows[k].value,
                dir_rows[k].size, dir_rows[k].typed, dir_rows[k].sol, dir_rows[k].conv);

    p = 0;
    while (items_sent < 24 + 320 && p < 16) begin
      idle_wait();
      cfg_write(pgs_pkg::CFG_ITER_LIMIT, {24'd0, lim_set[p % 8]});
      cfg_write(pgs_pkg::CFG_ERR_THRESH, thr_set[p % 8]);
      no_idle = (p % 4 == 3);
      start = items_sent;
      if (p == 0) run_sequence(16);
      while (items_sent - start < 45) run_sequence(pick_n());
      p++;
    end

    idle_wait();
    repeat (100) @(posedge clk);
    $display("covered %0d input items and %0d solves over %0d register settings",
             items_sent, solves_sent, p + 1);
    $display("checked %0d solution items, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0 && solution_q.size() == 0) begin
      $display("projected_gauss_seidel_solver test passed");
    end else begin
      $display("projected_gauss_seidel_solver test failed");
    end
    $finish;
  end

endmodule
